FILE: hdl/fmd_pkg.sv
// Shared types and constants for the fixed-map deque.
`timescale 1ns / 1ps

package fmd_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 7;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_READ_INDEX = 3'd4,
        CMD_WRITE_INDEX = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_DROP = 2'd1,
        ST_POP_EMPTY = 2'd2,
        ST_INDEX_OOR = 2'd3
    } status_t;

    // Where the result word comes from: the store read port or the held word.
    typedef enum logic {
        SRC_HELD  = 1'b0,
        SRC_STORE = 1'b1
    } data_src_t;

endpackage

FILE: hdl/fixed_map_deque.sv
// Fixed-map double-ended queue: one command per beat, one result per beat.
`timescale 1ns / 1ps

// Channel  Ports                                   Direction
// s_       s_valid s_ready s_command s_value s_index  command in
// m_       m_valid m_ready m_data m_count m_status    result out
//
// One command per cycle while results flow; each result shows in the cycle after
// its command beat, out of the result register and the store's registered read port.
// Pointers, error cell and store update at the command beat, so the next
// command sees them at once. Reset empties the deque (both ends at the
// centre slot) and clears the error cell; the store is not cleared.
// A stalled result holds its register and blocks new commands until taken.
module fixed_map_deque #(
    parameter int BLOCK_COUNT = 11,
    parameter int BLOCK_SIZE  = 10,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fmd_pkg::CMD_W-1:0]         s_command,
    input  logic signed [fmd_pkg::VALUE_W-1:0] s_value,
    input  logic [fmd_pkg::INDEX_W-1:0]       s_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fmd_pkg::VALUE_W-1:0] m_data,
    output logic [fmd_pkg::COUNT_W-1:0]       m_count,
    output logic [fmd_pkg::STATUS_W-1:0]      m_status
);

    localparam int SLOT_TOTAL  = BLOCK_COUNT * BLOCK_SIZE;
    localparam int CENTRE_SLOT = (BLOCK_COUNT / 2) * BLOCK_SIZE + BLOCK_SIZE / 2;
    localparam int PTR_W       = $clog2(SLOT_TOTAL + 1);
    localparam int ADDR_W      = $clog2(SLOT_TOTAL);
    localparam int CMP_W       = (PTR_W > fmd_pkg::INDEX_W) ? PTR_W : fmd_pkg::INDEX_W;
    localparam int WIDE_W      = (CMP_W > fmd_pkg::COUNT_W) ? CMP_W : fmd_pkg::COUNT_W;

    // Storage
    logic [DATA_WIDTH-1:0] mem [SLOT_TOTAL];
    logic [DATA_WIDTH-1:0] mem_rd_reg;

    // Control and result registers
    logic [PTR_W-1:0]            head_reg, head_next;
    logic [PTR_W-1:0]            tail_reg, tail_next;
    logic [DATA_WIDTH-1:0]       err_reg, err_next;
    logic                        valid_reg;
    logic [DATA_WIDTH-1:0]       word_reg, word_next;
    fmd_pkg::data_src_t          src_reg, src_next;
    logic [fmd_pkg::COUNT_W-1:0] count_reg, count_next;
    fmd_pkg::status_t            status_reg, status_next;

    logic                        accept;
    logic                        wr_en, rd_en;
    logic [ADDR_W-1:0]           wr_addr, rd_addr;
    logic [DATA_WIDTH-1:0]       val_word;
    logic [PTR_W-1:0]            cnt;
    logic [CMP_W-1:0]            idx_wide, cnt_wide;
    logic                        idx_ok;
    logic [PTR_W-1:0]            idx_addr;
    logic [WIDE_W-1:0]           cnt_next_wide;
    logic [DATA_WIDTH-1:0]       out_word;

    assign accept  = s_valid && s_ready;
    assign s_ready = !valid_reg || m_ready;

    // Fit the incoming value to the store width
    generate
        if (DATA_WIDTH >= fmd_pkg::VALUE_W) begin : g_val_wide
            assign val_word = DATA_WIDTH'($unsigned(s_value));
        end else begin : g_val_narrow
            assign val_word = s_value[DATA_WIDTH-1:0];
        end
    endgenerate

    assign cnt      = tail_reg - head_reg;
    assign idx_wide = CMP_W'(s_index);
    assign cnt_wide = CMP_W'(cnt);
    assign idx_ok   = idx_wide < cnt_wide;
    assign idx_addr = head_reg + PTR_W'(s_index);

    always_comb begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        err_next    = err_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        wr_addr     = '0;
        rd_addr     = '0;
        word_next   = '0;
        src_next    = fmd_pkg::SRC_HELD;
        status_next = fmd_pkg::ST_OK;
        unique case (s_command)
            fmd_pkg::CMD_PUSH_BACK: begin
                if (tail_reg < PTR_W'(SLOT_TOTAL)) begin
                    wr_en     = 1'b1;
                    wr_addr   = tail_reg[ADDR_W-1:0];
                    tail_next = tail_reg + 1'b1;
                end else begin
                    status_next = fmd_pkg::ST_PUSH_DROP;
                end
            end
            fmd_pkg::CMD_PUSH_FRONT: begin
                if (head_reg != '0) begin
                    wr_en     = 1'b1;
                    head_next = head_reg - 1'b1;
                    wr_addr   = head_next[ADDR_W-1:0];
                end else begin
                    status_next = fmd_pkg::ST_PUSH_DROP;
                end
            end
            fmd_pkg::CMD_POP_BACK: begin
                if (cnt != '0) begin
                    rd_en     = 1'b1;
                    tail_next = tail_reg - 1'b1;
                    rd_addr   = tail_next[ADDR_W-1:0];
                    src_next  = fmd_pkg::SRC_STORE;
                end else begin
                    word_next   = err_reg;
                    status_next = fmd_pkg::ST_POP_EMPTY;
                end
            end
            fmd_pkg::CMD_POP_FRONT: begin
                if (cnt != '0) begin
                    rd_en     = 1'b1;
                    rd_addr   = head_reg[ADDR_W-1:0];
                    head_next = head_reg + 1'b1;
                    src_next  = fmd_pkg::SRC_STORE;
                end else begin
                    word_next   = err_reg;
                    status_next = fmd_pkg::ST_POP_EMPTY;
                end
            end
            fmd_pkg::CMD_READ_INDEX: begin
                if (idx_ok) begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_addr[ADDR_W-1:0];
                    src_next = fmd_pkg::SRC_STORE;
                end else begin
                    word_next   = err_reg;
                    status_next = fmd_pkg::ST_INDEX_OOR;
                end
            end
            fmd_pkg::CMD_WRITE_INDEX: begin
                word_next = val_word;
                if (idx_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = idx_addr[ADDR_W-1:0];
                end else begin
                    err_next    = val_word;
                    status_next = fmd_pkg::ST_INDEX_OOR;
                end
            end
            default: begin
                // unused commands: no change, zero data
            end
        endcase
        cnt_next_wide = WIDE_W'(tail_next - head_next);
        count_next    = cnt_next_wide[fmd_pkg::COUNT_W-1:0];
    end

    // Store write and registered read, both at the command beat
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            mem[wr_addr] <= val_word;
        end
        if (accept && rd_en) begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= PTR_W'(CENTRE_SLOT);
            tail_reg  <= PTR_W'(CENTRE_SLOT);
            err_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                err_reg   <= err_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg   <= word_next;
            src_reg    <= src_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign out_word = (src_reg == fmd_pkg::SRC_STORE) ? mem_rd_reg : word_reg;

    // Sign-extend a narrower store word, or cut a wider one, to the port width
    generate
        if (DATA_WIDTH >= fmd_pkg::VALUE_W) begin : g_out_wide
            assign m_data = out_word[fmd_pkg::VALUE_W-1:0];
        end else begin : g_out_narrow
            assign m_data = {{(fmd_pkg::VALUE_W - DATA_WIDTH){out_word[DATA_WIDTH-1]}},
                             out_word};
        end
    endgenerate

    assign m_valid  = valid_reg;
    assign m_count  = count_reg;
    assign m_status = status_reg;

endmodule

FILE: tb/sv/tb_fixed_map_deque.sv
// Self-checking testbench for the fixed-map deque: shadow deque, random traffic, stalls.
`timescale 1ns / 1ps

module tb_fixed_map_deque;

    localparam int BLOCK_COUNT  = 11;
    localparam int BLOCK_SIZE   = 10;
    localparam int DATA_WIDTH   = 32;
    localparam int SLOT_TOTAL   = BLOCK_COUNT * BLOCK_SIZE;
    localparam int CENTRE_SLOT  = (BLOCK_COUNT / 2) * BLOCK_SIZE + BLOCK_SIZE / 2;
    localparam int RANDOM_ITEMS = 500;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef logic [fmd_pkg::CMD_W-1:0]    cmd_word_t;
    typedef logic [fmd_pkg::VALUE_W-1:0]  value_word_t;
    typedef logic [fmd_pkg::INDEX_W-1:0]  index_word_t;
    typedef logic [fmd_pkg::COUNT_W-1:0]  count_word_t;
    typedef logic [fmd_pkg::STATUS_W-1:0] status_word_t;

    // Command codes the block leaves unused; they must answer as a no-op.
    localparam cmd_word_t CMD_SPARE_LO = 3'd6;
    localparam cmd_word_t CMD_SPARE_HI = 3'd7;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE,
        READY_PERIODIC
    } ready_mode_t;

    typedef enum int {
        PHASE_FILL_BACK,
        PHASE_FILL_FRONT,
        PHASE_DRAIN,
        PHASE_MIXED
    } traffic_phase_t;

    typedef struct packed {
        value_word_t      data;
        count_word_t      count;
        fmd_pkg::status_t status;
    } deque_result_t;

    class deque_shadow;
        value_word_t   slots [SLOT_TOTAL];
        int            head_pos;
        int            tail_pos;
        value_word_t   error_word;
        deque_result_t pending_results [$];
        int            mismatches;

        function new();
            foreach (slots[i]) slots[i] = '0;
            head_pos   = CENTRE_SLOT;
            tail_pos   = CENTRE_SLOT;
            error_word = '0;
            mismatches = 0;
        endfunction

        function int stored_words();
            return tail_pos - head_pos;
        endfunction

        function void note_command(cmd_word_t cmd, value_word_t value, index_word_t index);
            deque_result_t res;
            int            words;
            words      = tail_pos - head_pos;
            res.data   = '0;
            res.status = fmd_pkg::ST_OK;
            case (cmd)
                fmd_pkg::CMD_PUSH_BACK: begin
                    if (tail_pos < SLOT_TOTAL) begin
                        slots[tail_pos] = value;
                        tail_pos++;
                    end else begin
                        res.status = fmd_pkg::ST_PUSH_DROP;
                    end
                end
                fmd_pkg::CMD_PUSH_FRONT: begin
                    if (head_pos > 0) begin
                        head_pos--;
                        slots[head_pos] = value;
                    end else begin
                        res.status = fmd_pkg::ST_PUSH_DROP;
                    end
                end
                fmd_pkg::CMD_POP_BACK: begin
                    if (words > 0) begin
                        tail_pos--;
                        res.data = slots[tail_pos];
                    end else begin
                        res.data   = error_word;
                        res.status = fmd_pkg::ST_POP_EMPTY;
                    end
                end
                fmd_pkg::CMD_POP_FRONT: begin
                    if (words > 0) begin
                        res.data = slots[head_pos];
                        head_pos++;
                    end else begin
                        res.data   = error_word;
                        res.status = fmd_pkg::ST_POP_EMPTY;
                    end
                end
                fmd_pkg::CMD_READ_INDEX: begin
                    if (int'(index) < words) begin
                        res.data = slots[head_pos + int'(index)];
                    end else begin
                        res.data   = error_word;
                        res.status = fmd_pkg::ST_INDEX_OOR;
                    end
                end
                fmd_pkg::CMD_WRITE_INDEX: begin
                    if (int'(index) < words) begin
                        slots[head_pos + int'(index)] = value;
                    end else begin
                        error_word = value;
                        res.status = fmd_pkg::ST_INDEX_OOR;
                    end
                    res.data = value;
                end
                default: ;
            endcase
            res.count = count_word_t'(tail_pos - head_pos);
            pending_results.insert(pending_results.size(), res);
        endfunction

        function void check_result(value_word_t data, count_word_t count,
                                   status_word_t status);
            deque_result_t exp_res;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat data %h count %0d status %0d",
                         $realtime, data, count, status);
                return;
            end
            exp_res = pending_results[0];
            pending_results.delete(0);
            if (data !== exp_res.data) begin
                mismatches++;
                $display("%0t: data expected %h actual %h", $realtime, exp_res.data, data);
            end
            if (count !== exp_res.count) begin
                mismatches++;
                $display("%0t: count expected %0d actual %0d", $realtime, exp_res.count, count);
            end
            if (status !== exp_res.status) begin
                mismatches++;
                $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status,
                         status);
            end
        endfunction
    endclass

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [fmd_pkg::CMD_W-1:0]          s_command;
    logic signed [fmd_pkg::VALUE_W-1:0] s_value;
    logic [fmd_pkg::INDEX_W-1:0]        s_index;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [fmd_pkg::VALUE_W-1:0] m_data;
    logic [fmd_pkg::COUNT_W-1:0]        m_count;
    logic [fmd_pkg::STATUS_W-1:0]       m_status;

    deque_shadow shadow = new();
    int          cycle_count;
    ready_mode_t ready_mode;
    int          ready_left;

    fixed_map_deque #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .BLOCK_SIZE (BLOCK_SIZE),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_command(s_command),
        .s_value  (s_value),
        .s_index  (s_index),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .m_count  (m_count),
        .m_status (m_status)
    );

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_command   = '0;
        s_value     = '0;
        s_index     = '0;
        m_ready     = 1'b0;
        cycle_count = 0;
        ready_mode  = READY_ALWAYS;
        ready_left  = 0;
    end

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $realtime,
                     shadow.pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: switch between stall patterns after runs of random length.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(READY_ALWAYS, READY_PERIODIC));
            ready_left <= $urandom_range(20, 80);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS:   m_ready <= 1'b1;
            READY_HALF:     m_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
            READY_PERIODIC: m_ready <= (cycle_count % 5) != 0;
            default:        m_ready <= 1'b1;
        endcase
    end

    // Note the command beat before checking the result beat of the same edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            shadow.note_command(s_command, s_value, s_index);
        if (aresetn && m_valid && m_ready)
            shadow.check_result(m_data, m_count, m_status);
    end

    // Hold valid and payload until the beat is taken; leave valid high.
    task automatic send_command(input cmd_word_t cmd, input value_word_t value,
                                input index_word_t index);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_value   <= value;
        s_index   <= index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    initial begin
        int             sent;
        int             seg;
        int             seg_len;
        int             burst_len;
        int             roll;
        int             words;
        traffic_phase_t phase;
        cmd_word_t      cmd;
        value_word_t    value;
        index_word_t    index;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cases, error cell, extremes of value and index, spare codes.
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_BACK,    32'hFFFF_FFFF, 7'd127);
        send_command(fmd_pkg::CMD_POP_FRONT,   32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_WRITE_INDEX, 32'h8000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_FRONT,   32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_PUSH_BACK,   32'h7FFF_FFFF, 7'd0);
        send_command(fmd_pkg::CMD_PUSH_FRONT,  32'h8000_0000, 7'd127);
        send_command(fmd_pkg::CMD_PUSH_BACK,   32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_PUSH_FRONT,  32'hFFFF_FFFF, 7'd0);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd3);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd4);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'hFFFF_FFFF, 7'd127);
        send_command(fmd_pkg::CMD_WRITE_INDEX, 32'h5555_5555, 7'd1);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd1);
        send_command(fmd_pkg::CMD_WRITE_INDEX, 32'hAAAA_AAAA, 7'd109);
        send_command(fmd_pkg::CMD_READ_INDEX,  32'h0000_0000, 7'd100);
        send_command(CMD_SPARE_LO,             32'h1234_5678, 7'd5);
        send_command(CMD_SPARE_HI,             32'hFFFF_FFFF, 7'd127);
        send_command(fmd_pkg::CMD_POP_BACK,    32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_FRONT,   32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_BACK,    32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_FRONT,   32'h0000_0000, 7'd0);
        send_command(fmd_pkg::CMD_POP_FRONT,   32'h0000_0000, 7'd0);

        // Random: segments biased to reach both edges, drain, and mixed access.
        sent = 0;
        seg  = 0;
        while (sent < RANDOM_ITEMS) begin
            if (seg < 2)
                phase = traffic_phase_t'(seg);
            else
                phase = traffic_phase_t'($urandom_range(PHASE_FILL_BACK, PHASE_MIXED));
            seg_len = $urandom_range(40, 90);
            seg++;
            while (seg_len > 0 && sent < RANDOM_ITEMS) begin
                burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 12);
                repeat (burst_len) begin
                    roll = $urandom_range(0, 99);
                    case (phase)
                        PHASE_FILL_BACK:
                            cmd = (roll < 92) ? fmd_pkg::CMD_PUSH_BACK
                                              : cmd_word_t'($urandom_range(0, 7));
                        PHASE_FILL_FRONT:
                            cmd = (roll < 92) ? fmd_pkg::CMD_PUSH_FRONT
                                              : cmd_word_t'($urandom_range(0, 7));
                        PHASE_DRAIN:
                            cmd = (roll < 45) ? fmd_pkg::CMD_POP_BACK :
                                  (roll < 90) ? fmd_pkg::CMD_POP_FRONT
                                              : cmd_word_t'($urandom_range(0, 7));
                        default:
                            cmd = (roll < 15) ? fmd_pkg::CMD_PUSH_BACK :
                                  (roll < 30) ? fmd_pkg::CMD_PUSH_FRONT :
                                  (roll < 42) ? fmd_pkg::CMD_POP_BACK :
                                  (roll < 54) ? fmd_pkg::CMD_POP_FRONT :
                                  (roll < 75) ? fmd_pkg::CMD_READ_INDEX :
                                  (roll < 96) ? fmd_pkg::CMD_WRITE_INDEX :
                                  (roll < 98) ? CMD_SPARE_LO : CMD_SPARE_HI;
                    endcase
                    case ($urandom_range(0, 9))
                        0:       value = 32'h7FFF_FFFF;
                        1:       value = 32'h8000_0000;
                        2:       value = 32'h0000_0000;
                        3:       value = 32'hFFFF_FFFF;
                        default: value = $urandom;
                    endcase
                    // Aim most indexed accesses at occupied slots.
                    words = shadow.stored_words();
                    if (words > 0 && $urandom_range(0, 3) != 0)
                        index = index_word_t'($urandom_range(0, words - 1));
                    else
                        index = index_word_t'($urandom_range(0, 127));
                    send_command(cmd, value, index);
                    sent++;
                    seg_len--;
                end
                idle_for(($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6));
            end
        end
        s_valid <= 1'b0;

        while (shadow.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.pending_results.size() != 0) begin
            shadow.mismatches++;
            $display("%0t: %0d expected results never arrived", $realtime,
                     shadow.pending_results.size());
        end

        if (shadow.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
